>>> rtl/core/nljmc_pkg.sv
package nljmc_pkg;

  // default sizing
  localparam int unsigned DEF_MAX_R_TUPLES = 1024;
  localparam int unsigned DEF_MAX_S_TUPLES = 1024;
  localparam int unsigned DEF_KEY_BITS     = 32;

  // fixed field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned IN_KEY_W = 32;
  localparam int unsigned COUNT_W  = 21;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_R = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_S = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_r;
    logic load_s;
    logic run_start;
    logic scan_step;
    logic post;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last_pair;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/nljmc_if.sv
interface nljmc_in_if import nljmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IN_KEY_W-1:0] tuple_key;

  modport source (output valid, output kind, output tuple_key, input ready);
  modport sink   (input valid, input kind, input tuple_key, output ready);
endinterface

interface nljmc_out_if import nljmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] match_count;
  logic               overflow;

  modport source (output valid, output match_count, output overflow, input ready);
  modport sink   (input valid, input match_count, input overflow, output ready);
endinterface

>>> rtl/core/nljmc_ctrl.sv
module nljmc_ctrl import nljmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_POST  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind_i)
            KIND_LOAD_R: cmd_o.load_r = 1'b1;
            KIND_LOAD_S: cmd_o.load_s = 1'b1;
            KIND_RUN: begin
              cmd_o.run_start = 1'b1;
              state_d = sts_i.empty ? ST_POST : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last_pair) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_POST;
      ST_POST: begin
        if (sts_i.out_free) begin
          cmd_o.post = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/nljmc_dpath.sv
module nljmc_dpath import nljmc_pkg::*; #(
  parameter int unsigned MAX_R_TUPLES = DEF_MAX_R_TUPLES,
  parameter int unsigned MAX_S_TUPLES = DEF_MAX_S_TUPLES,
  parameter int unsigned KEY_BITS     = DEF_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IN_KEY_W-1:0] tuple_key_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COUNT_W-1:0]  match_count_o,
  output logic                overflow_o
);

  localparam int unsigned KW   = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int unsigned RAW  = (MAX_R_TUPLES > 1) ? $clog2(MAX_R_TUPLES) : 1;
  localparam int unsigned SAW  = (MAX_S_TUPLES > 1) ? $clog2(MAX_S_TUPLES) : 1;
  localparam int unsigned RFW  = $clog2(MAX_R_TUPLES + 1);
  localparam int unsigned SFW  = $clog2(MAX_S_TUPLES + 1);

  logic [KW-1:0]      r_mem [MAX_R_TUPLES];
  logic [KW-1:0]      s_mem [MAX_S_TUPLES];
  logic [KW-1:0]      r_rdata_q, s_rdata_q;
  logic [RFW-1:0]     r_fill_q;
  logic [SFW-1:0]     s_fill_q;
  logic [RAW-1:0]     i_q;
  logic [SAW-1:0]     j_q;
  logic               drop_q;
  logic               cmp_v_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_ovf_q;
  logic               r_full, s_full, i_last, j_last;

  assign r_full = (r_fill_q == RFW'(MAX_R_TUPLES));
  assign s_full = (s_fill_q == SFW'(MAX_S_TUPLES));
  assign i_last = ((RFW'(i_q) + RFW'(1)) == r_fill_q);
  assign j_last = ((SFW'(j_q) + SFW'(1)) == s_fill_q);

  assign sts_o.empty     = (r_fill_q == '0) || (s_fill_q == '0);
  assign sts_o.last_pair = i_last & j_last;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  // key stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_r && !r_full) r_mem[r_fill_q[RAW-1:0]] <= tuple_key_i[KW-1:0];
    r_rdata_q <= r_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_s && !s_full) s_mem[s_fill_q[SAW-1:0]] <= tuple_key_i[KW-1:0];
    s_rdata_q <= s_mem[j_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_fill_q    <= '0;
      s_fill_q    <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      cmp_v_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_step;

      if (cmd_i.load_r) begin
        if (r_full) drop_q <= 1'b1;
        else        r_fill_q <= r_fill_q + RFW'(1);
      end
      if (cmd_i.load_s) begin
        if (s_full) drop_q <= 1'b1;
        else        s_fill_q <= s_fill_q + SFW'(1);
      end

      // row-major walk over all r x s pairs
      if (cmd_i.run_start) begin
        i_q <= '0;
        j_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + RAW'(1);
        end else begin
          j_q <= j_q + SAW'(1);
        end
      end

      // saturating match counter
      if (cmd_i.run_start) begin
        count_q <= '0;
      end else if (cmp_v_q && (r_rdata_q == s_rdata_q) && (count_q != '1)) begin
        count_q <= count_q + COUNT_W'(1);
      end

      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
        r_fill_q    <= '0;
        s_fill_q    <= '0;
        drop_q      <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      out_count_q <= count_q;
      out_ovf_q   <= drop_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_count_q;
  assign overflow_o    = out_ovf_q;

endmodule

>>> rtl/core/nested_loop_join_match_counter_unit.sv
// equi-join match counter. each input word carries a kind and a key: kind load r and
// load s append the key to the r or s key store at one word per cycle; a load into a
// full store is dropped and flags overflow. kind run compares every stored r key
// against every stored s key and returns one result word with the number of equal
// pairs (saturating at the top of the 21-bit field) and the overflow flag, then
// empties both stores. kind 3 is ignored. keys are compared on their low KEY_BITS
// bits (at most 32). a run scans one pair per cycle through the single read port of
// each store, with a registered read of both keys ahead of the compare and count;
// it skips the scan when either store is empty and posts the result only once the
// previous result word has been taken. no input is accepted during a run; loads
// continue while a result word is still waiting on the output register.
module nested_loop_join_match_counter_unit import nljmc_pkg::*; #(
  parameter int unsigned MAX_R_TUPLES = DEF_MAX_R_TUPLES,
  parameter int unsigned MAX_S_TUPLES = DEF_MAX_S_TUPLES,
  parameter int unsigned KEY_BITS     = DEF_KEY_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nljmc_in_if.sink      in_i,
  nljmc_out_if.source   out_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts words, steps the pair scan, posts the result
  nljmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: key stores, fill counts, pair indices, comparator, counter, output reg
  nljmc_dpath #(
    .MAX_R_TUPLES (MAX_R_TUPLES),
    .MAX_S_TUPLES (MAX_S_TUPLES),
    .KEY_BITS     (KEY_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tuple_key_i   (in_i.tuple_key),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .match_count_o (out_o.match_count),
    .overflow_o    (out_o.overflow)
  );

endmodule
